>>> rtl/core/flr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// flr_pkg
// Shared types and constants of the flood/learn route forwarder: field
// codes, register indexes and the command and status words that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package flr_pkg;

    localparam int NODE_SPACE_DEF = 256;
    localparam int MAX_PORTS_DEF  = 8;
    localparam int RESULT_CAP     = 8;

    localparam logic [7:0] KIND_DISCOVERY = 8'd2;
    localparam logic [7:0] HOP_MAX        = 8'd255;
    localparam logic [7:0] HOP_START      = 8'd1;

    localparam logic CFG_NODE_ID   = 1'b0;
    localparam logic CFG_NUM_PORTS = 1'b1;

    typedef enum logic [1:0] {
        SEL_FLOOD,
        SEL_DELIVER,
        SEL_ROUTE
    } t_out_sel;

    typedef struct packed {
        logic     load_item;
        logic     clr_wr;
        logic     sweep_rst;
        logic     sweep_inc;
        logic     fz_rd;
        logic     learn_first;
        logic     learn_upd;
        logic     port_rst;
        logic     port_inc;
        logic     out_load;
        t_out_sel out_sel;
    } t_ctl_cmd;

    typedef struct packed {
        logic is_start;
        logic kind_disc;
        logic disc;
        logic dst_self;
        logic src_self;
        logic src_in_range;
        logic src_seen;
        logic sweep_last;
        logic port_last;
        logic n_zero;
        logic out_free;
    } t_dp_status;

    function automatic logic [7:0] hop_plus(input logic [7:0] h);
        return (h == HOP_MAX) ? HOP_MAX : h + 8'd1;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/flr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// flr_ctrl
// Sequencer of the forwarder: clearing pass after reset, item lookup and
// decision, one-time table freeze sweep and the per-port flood loop.
// ----------------------------------------------------------------------------
module flr_ctrl
    import flr_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  t_dp_status i_st,
    output t_ctl_cmd   o_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_DECIDE,
        S_FREEZE,
        S_FZ_END,
        S_RLOOK,
        S_FLOOD,
        S_DELIVER,
        S_ROUTE
    } t_state;

    t_state r_state, n_state;
    logic   r_frozen, n_frozen;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_frozen = r_frozen;
        o_cmd    = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr    = 1'b1;
                o_cmd.sweep_inc = 1'b1;
                if (i_st.sweep_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    o_cmd.port_rst  = 1'b1;
                    n_state         = S_LOOK;
                end
            end
            S_LOOK: n_state = S_DECIDE;
            S_DECIDE: begin
                if (i_st.is_start) begin
                    n_state = S_FLOOD;
                end else if (i_st.disc && i_st.dst_self) begin
                    n_state = S_IDLE;          // own discovery came back: drop
                end else if (!i_st.kind_disc && i_st.dst_self) begin
                    n_state = S_DELIVER;
                end else if (i_st.disc) begin
                    if (i_st.src_in_range && i_st.src_seen) begin
                        o_cmd.learn_upd = !i_st.src_self;
                        n_state         = S_IDLE;
                    end else begin
                        o_cmd.learn_first = i_st.src_in_range;
                        n_state           = S_FLOOD;
                    end
                end else if (!r_frozen) begin
                    o_cmd.sweep_rst = 1'b1;
                    n_state         = S_FREEZE;
                end else begin
                    n_state = S_ROUTE;
                end
            end
            S_FREEZE: begin
                o_cmd.fz_rd     = 1'b1;
                o_cmd.sweep_inc = 1'b1;
                if (i_st.sweep_last) n_state = S_FZ_END;
            end
            S_FZ_END: begin
                n_frozen = 1'b1;
                n_state  = S_RLOOK;
            end
            S_RLOOK: n_state = S_ROUTE;
            S_FLOOD: begin
                o_cmd.out_sel = SEL_FLOOD;
                if (i_st.n_zero) begin
                    n_state = S_IDLE;
                end else if (i_st.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.port_inc = 1'b1;
                    if (i_st.port_last) n_state = S_IDLE;
                end
            end
            S_DELIVER: begin
                o_cmd.out_sel = SEL_DELIVER;
                if (i_st.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_ROUTE: begin
                o_cmd.out_sel = SEL_ROUTE;
                if (i_st.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_frozen <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_frozen <= n_frozen;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/flr_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// flr_dpath
// Datapath of the forwarder: configuration registers, item register, the
// seen/learned and route memories, sweep and port counters, output register.
// ----------------------------------------------------------------------------
module flr_dpath
    import flr_pkg::*;
#(
    parameter int NODE_SPACE = NODE_SPACE_DEF,
    parameter int MAX_PORTS  = MAX_PORTS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire         i_cfg_idx,
    input  wire  [7:0]  i_cfg_data,
    input  wire         i_cmd,
    input  wire  [7:0]  i_pkt_kind,
    input  wire  [7:0]  i_src_node,
    input  wire  [7:0]  i_dst_node,
    input  wire  [7:0]  i_hops_in,
    input  wire  [2:0]  i_arrival_port,
    input  wire  [2:0]  i_carried_port,
    input  wire         i_out_stall,
    output logic        o_out_valid,
    output logic        o_action,
    output logic [2:0]  o_send_port,
    output logic [7:0]  o_out_kind,
    output logic [7:0]  o_out_src,
    output logic [7:0]  o_out_dst,
    output logic [7:0]  o_hops_out,
    output logic        o_last,
    input  t_ctl_cmd    i_cmd_w,
    output t_dp_status  o_st
);

    localparam int AW      = (NODE_SPACE > 1) ? $clog2(NODE_SPACE) : 1;
    localparam int PORTCAP = (MAX_PORTS < RESULT_CAP) ? MAX_PORTS : RESULT_CAP;
    localparam logic [3:0]    PORT_CAP_W = 4'(PORTCAP);
    localparam logic [AW-1:0] LAST_ADDR  = AW'(NODE_SPACE - 1);

    // configuration
    logic [7:0] r_node_id;
    logic [3:0] r_num_ports;

    // item
    logic       r_cmd;
    logic [7:0] r_kind, r_src, r_dst, r_hops;
    logic [2:0] r_arr, r_carried;

    // memories and their registered read data
    logic       r_seen_mem   [NODE_SPACE];
    logic [7:0] r_lcost_mem  [NODE_SPACE];
    logic [2:0] r_lport_mem  [NODE_SPACE];
    logic       r_rvalid_mem [NODE_SPACE];
    logic [2:0] r_rport_mem  [NODE_SPACE];
    logic       r_seen_rd, r_rvalid_rd;
    logic [7:0] r_lcost_rd;
    logic [2:0] r_lport_rd, r_rport_rd;

    // counters
    logic [AW-1:0] r_sweep, r_fz_addr;
    logic          r_fz_pend;
    logic [2:0]    r_port;

    // output word
    logic       r_out_valid, r_action, r_last;
    logic [2:0] r_send_port;
    logic [7:0] r_out_kind, r_out_src, r_out_dst, r_hops_out;

    logic [AW-1:0] idx_src, idx_dst, rd_addr, seen_waddr;
    logic [3:0]    n_ports;
    logic          src_in_range, dst_in_range, better, out_free, port_last;
    logic          seen_we, seen_wd, learn_we, rvalid_we, rvalid_wd;
    logic [AW-1:0] rvalid_waddr;
    logic [7:0]    hop_next;

    assign idx_src      = AW'(r_src);
    assign idx_dst      = AW'(r_dst);
    assign src_in_range = (32'(r_src) < NODE_SPACE);
    assign dst_in_range = (32'(r_dst) < NODE_SPACE);
    assign n_ports      = (r_num_ports > PORT_CAP_W) ? PORT_CAP_W : r_num_ports;
    assign port_last    = ((4'(r_port) + 4'd1) == n_ports);
    assign better       = (r_hops < r_lcost_rd) ||
                          ((r_hops == r_lcost_rd) && (r_arr < r_lport_rd));
    assign out_free     = !r_out_valid || !i_out_stall;
    assign hop_next     = hop_plus(r_hops);

    assign o_st.is_start     = r_cmd;
    assign o_st.kind_disc    = (r_kind == KIND_DISCOVERY);
    assign o_st.disc         = (r_kind == KIND_DISCOVERY) && (r_hops != 8'd0);
    assign o_st.dst_self     = (r_dst == r_node_id);
    assign o_st.src_self     = (r_src == r_node_id);
    assign o_st.src_in_range = src_in_range;
    assign o_st.src_seen     = r_seen_rd;
    assign o_st.sweep_last   = (r_sweep == LAST_ADDR);
    assign o_st.port_last    = port_last;
    assign o_st.n_zero       = (n_ports == 4'd0);
    assign o_st.out_free     = out_free;

    // configuration and item registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id   <= 8'd0;
            r_num_ports <= 4'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NODE_ID:   r_node_id   <= i_cfg_data;
                CFG_NUM_PORTS: r_num_ports <= i_cfg_data[3:0];
                default:       r_node_id   <= r_node_id;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_w.load_item) begin
            r_cmd     <= i_cmd;
            r_kind    <= i_pkt_kind;
            r_src     <= i_src_node;
            r_dst     <= i_dst_node;
            r_hops    <= i_hops_in;
            r_arr     <= i_arrival_port;
            r_carried <= i_carried_port;
        end
    end

    // memory write controls
    assign rd_addr      = i_cmd_w.fz_rd ? r_sweep : idx_src;
    assign seen_we      = i_cmd_w.clr_wr || i_cmd_w.learn_first;
    assign seen_wd      = !i_cmd_w.clr_wr;
    assign seen_waddr   = i_cmd_w.clr_wr ? r_sweep : idx_src;
    assign learn_we     = i_cmd_w.learn_first || (i_cmd_w.learn_upd && better);
    assign rvalid_we    = i_cmd_w.clr_wr || r_fz_pend;
    assign rvalid_wd    = !i_cmd_w.clr_wr && r_seen_rd;
    assign rvalid_waddr = i_cmd_w.clr_wr ? r_sweep : r_fz_addr;

    always_ff @(posedge i_clk) begin
        if (seen_we) r_seen_mem[seen_waddr] <= seen_wd;
        if (learn_we) begin
            r_lcost_mem[idx_src] <= r_hops;
            r_lport_mem[idx_src] <= r_arr;
        end
        if (rvalid_we) r_rvalid_mem[rvalid_waddr] <= rvalid_wd;
        if (r_fz_pend) r_rport_mem[r_fz_addr] <= r_lport_rd;
        r_seen_rd   <= r_seen_mem[rd_addr];
        r_lcost_rd  <= r_lcost_mem[rd_addr];
        r_lport_rd  <= r_lport_mem[rd_addr];
        r_rvalid_rd <= r_rvalid_mem[idx_dst];
        r_rport_rd  <= r_rport_mem[idx_dst];
        r_fz_addr   <= r_sweep;
    end

    // sweep and port counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep   <= '0;
            r_fz_pend <= 1'b0;
            r_port    <= 3'd0;
        end else begin
            r_fz_pend <= i_cmd_w.fz_rd;
            if (i_cmd_w.sweep_rst)      r_sweep <= '0;
            else if (i_cmd_w.sweep_inc) r_sweep <= r_sweep + AW'(1);
            if (i_cmd_w.port_rst)       r_port  <= 3'd0;
            else if (i_cmd_w.port_inc)  r_port  <= r_port + 3'd1;
        end
    end

    // output word: hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd_w.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_w.out_load) begin
            case (i_cmd_w.out_sel)
                SEL_FLOOD: begin
                    r_action    <= 1'b0;
                    r_send_port <= r_port;
                    r_last      <= port_last;
                    if (r_cmd) begin
                        r_out_kind <= KIND_DISCOVERY;
                        r_out_src  <= r_node_id;
                        r_out_dst  <= r_node_id;
                        r_hops_out <= HOP_START;
                    end else begin
                        r_out_kind <= r_kind;
                        r_out_src  <= r_src;
                        r_out_dst  <= r_dst;
                        r_hops_out <= hop_next;
                    end
                end
                SEL_DELIVER: begin
                    r_action    <= 1'b1;
                    r_send_port <= 3'd0;
                    r_last      <= 1'b1;
                    r_out_kind  <= r_kind;
                    r_out_src   <= r_src;
                    r_out_dst   <= r_dst;
                    r_hops_out  <= r_hops;
                end
                default: begin
                    r_action    <= 1'b0;
                    r_send_port <= (dst_in_range && r_rvalid_rd) ? r_rport_rd : r_carried;
                    r_last      <= 1'b1;
                    r_out_kind  <= r_kind;
                    r_out_src   <= r_src;
                    r_out_dst   <= r_dst;
                    r_hops_out  <= hop_next;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_action    = r_action;
    assign o_send_port = r_send_port;
    assign o_out_kind  = r_out_kind;
    assign o_out_src   = r_out_src;
    assign o_out_dst   = r_out_dst;
    assign o_hops_out  = r_hops_out;
    assign o_last      = r_last;

endmodule
`default_nettype wire

>>> rtl/core/flood_learn_route_forwarder_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// flood_learn_route_forwarder_top
// Forwarding engine of one node: floods discovery packets, learns the best
// arrival port per source and routes other packets through a frozen table.
//
// Input channel (i_in_valid / o_in_stall) takes one word per item: a start
// command or an arriving packet. Output channel (o_out_valid / i_out_stall)
// gives zero to eight result words per item, o_last marking the final one.
// Configuration (node_id, num_ports) is written on i_cfg_we; the user must
// write it only while the block is idle, which the block does not enforce.
// One item is worked at a time: it is looked up and decided on, then a flood
// issues one word per cycle while the receiver does not stall, one per port
// in use. A drop or a learning update gives no word. The first routed packet
// also triggers the table freeze sweep, which copies one entry per cycle of
// the seen flags and learned ports into the route table. After reset a
// clearing pass over every entry empties the seen and route-valid tables;
// o_in_stall stays high meanwhile. When the receiver
// stalls, the output word holds and the flood loop waits on it.
// ----------------------------------------------------------------------------
module flood_learn_route_forwarder_top
    import flr_pkg::*;
#(
    parameter int NODE_SPACE = NODE_SPACE_DEF,
    parameter int MAX_PORTS  = MAX_PORTS_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire        i_cfg_idx,
    input  wire  [7:0] i_cfg_data,
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  wire        i_cmd,
    input  wire  [7:0] i_pkt_kind,
    input  wire  [7:0] i_src_node,
    input  wire  [7:0] i_dst_node,
    input  wire  [7:0] i_hops_in,
    input  wire  [2:0] i_arrival_port,
    input  wire  [2:0] i_carried_port,
    output logic       o_out_valid,
    input  wire        i_out_stall,
    output logic       o_action,
    output logic [2:0] o_send_port,
    output logic [7:0] o_out_kind,
    output logic [7:0] o_out_src,
    output logic [7:0] o_out_dst,
    output logic [7:0] o_hops_out,
    output logic       o_last
);

    t_ctl_cmd   ctl_cmd;
    t_dp_status dp_st;

    flr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_st       (dp_st),
        .o_cmd      (ctl_cmd)
    );

    flr_dpath #(
        .NODE_SPACE (NODE_SPACE),
        .MAX_PORTS  (MAX_PORTS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (i_cmd),
        .i_pkt_kind     (i_pkt_kind),
        .i_src_node     (i_src_node),
        .i_dst_node     (i_dst_node),
        .i_hops_in      (i_hops_in),
        .i_arrival_port (i_arrival_port),
        .i_carried_port (i_carried_port),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_action       (o_action),
        .o_send_port    (o_send_port),
        .o_out_kind     (o_out_kind),
        .o_out_src      (o_out_src),
        .o_out_dst      (o_out_dst),
        .o_hops_out     (o_hops_out),
        .o_last         (o_last),
        .i_cmd_w        (ctl_cmd),
        .o_st           (dp_st)
    );

endmodule
`default_nettype wire

>>> tb/sv/tb_flood_learn_route_forwarder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_flood_learn_route_forwarder_top
// Self-checking bench for the flood/learn route forwarder. A table of
// directed packets and start commands goes first: reset values, extreme
// fields, drops, learning, the table freeze and odd port counts. Random
// phases follow, each with its own node address and port count. Each word
// is checked against a bench-side model of the seen, learned and route
// tables or against a directed row's own word. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_flood_learn_route_forwarder_top;
    import flr_pkg::*;

    localparam int DRAIN_CYCLES = 300;   // freeze sweep plus a full flood
    localparam int HOLD_CYCLES  = 400;
    localparam int NUM_PHASES   = 7;
    localparam int PHASE_ITEMS  = 50;
    localparam int POOL_SIZE    = 12;

    typedef enum logic {CMD_PACKET = 1'b0, CMD_START = 1'b1} t_cmd;
    typedef enum logic {ACT_SEND = 1'b0, ACT_DELIVER = 1'b1} t_action;
    typedef enum logic [1:0] {EXP_PREDICTED, EXP_SILENT, EXP_TYPED} t_exp_mode;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] kind;
        logic [7:0] src;
        logic [7:0] dst;
        logic [7:0] hops;
        logic [2:0] arr;
        logic [2:0] car;
    } t_pkt;

    typedef struct packed {
        t_action    action;
        logic [2:0] port;
        logic [7:0] kind;
        logic [7:0] src;
        logic [7:0] dst;
        logic [7:0] hops;
        logic       last;
    } t_fwd_word;

    typedef struct packed {
        logic       do_cfg;
        logic [7:0] node;
        logic [3:0] ports;
        t_pkt       pkt;
        t_exp_mode  mode;
        t_fwd_word  word;
    } t_row;

    localparam t_fwd_word NO_WORD = '0;

    localparam t_row DIRECTED [25] = '{
        // reset values: node 0, one port
        '{1'b0, 8'h00, 4'd0, '{CMD_PACKET, 8'h00, 8'h12, 8'h00, 8'hFF, 3'd7, 3'd7},
          EXP_TYPED, '{ACT_DELIVER, 3'd0, 8'h00, 8'h12, 8'h00, 8'hFF, 1'b1}},
        '{1'b0, 8'h00, 4'd0, '{CMD_START, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd7, 3'd7},
          EXP_TYPED, '{ACT_SEND, 3'd0, 8'h02, 8'h00, 8'h00, 8'h01, 1'b1}},
        '{1'b1, 8'hFF, 4'd8, '{CMD_START, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 3'd0},
          EXP_PREDICTED, NO_WORD},
        // own discovery back home
        '{1'b0, 8'h00, 4'd0, '{CMD_PACKET, 8'h02, 8'h33, 8'hFF, 8'h05, 3'd0, 3'd0},
          EXP_SILENT, NO_WORD},
        // first sighting, then cheaper, lower-port and dearer duplicates
        '{1'b0, 8'h00, 4'd0, '{CMD_PACKET, 8'h02, 8'h10, 8'h20, 8'h03, 3'd5, 3'd2},
          EXP_PREDICTED, NO_WORD},
        '{1'b0, 8'h00, 4'd0, '{CMD_PACKET, 8'h02, 8'h10, 8'h20, 8'h02, 3'd6, 3'd0},
          EXP_SILENT, NO_WORD},
        '{1'b0, 8'h00, 4'd0, '{CMD_PACKET, 8'h02, 8'h10, 8'h21, 8'h02, 3'd1, 3'd0},
          EXP_SILENT, NO_WORD},
        '{1'b0, 8'h00, 4'd0, '{CMD_PACKET, 8'h02, 8'h10, 8'h22, 8'h09, 3'd0, 3'd0},
          EXP_SILENT, NO_WORD},
        // source equal to own address: learnt once, flooded with saturated hop
        '{1'b0, 8'h00, 4'd0, '{CMD_PACKET, 8'h02, 8'hFF, 8'h00, 8'hFF, 3'd3, 3'd0},
          EXP_PREDICTED, NO_WORD},
        '{1'b0, 8'h00, 4'd0, '{CMD_PACKET, 8'h02, 8'hFF, 8'h01, 8'h01, 3'd0, 3'd0},
          EXP_SILENT, NO_WORD},
        '{1'b0, 8'h00, 4'd0, '{CMD_PACKET, 8'h02, 8'h00, 8'h01, 8'h01, 3'd7, 3'd0},
          EXP_PREDICTED, NO_WORD},
        // discovery kind with hop 0 freezes the table and is routed
        '{1'b0, 8'h00, 4'd0, '{CMD_PACKET, 8'h02, 8'hAA, 8'h10, 8'h00, 3'd0, 3'd6},
          EXP_PREDICTED, NO_WORD},
        '{1'b0, 8'h00, 4'd0, '{CMD_PACKET, 8'h02, 8'h01, 8'hFF, 8'h00, 3'd0, 3'd6},
          EXP_PREDICTED, NO_WORD},
        '{1'b0, 8'h00, 4'd0, '{CMD_PACKET, 8'hFF, 8'h00, 8'h77, 8'hFF, 3'd0, 3'd5},
          EXP_TYPED, '{ACT_SEND, 3'd5, 8'hFF, 8'h00, 8'h77, 8'hFF, 1'b1}},
        // learnt after the freeze: route table stays as it was
        '{1'b0, 8'h00, 4'd0, '{CMD_PACKET, 8'h02, 8'h40, 8'h41, 8'h01, 3'd2, 3'd0},
          EXP_PREDICTED, NO_WORD},
        '{1'b0, 8'h00, 4'd0, '{CMD_PACKET, 8'h03, 8'h40, 8'h40, 8'h10, 3'd0, 3'd4},
          EXP_TYPED, '{ACT_SEND, 3'd4, 8'h03, 8'h40, 8'h40, 8'h11, 1'b1}},
        '{1'b0, 8'h00, 4'd0, '{CMD_PACKET, 8'h80, 8'h55, 8'hFF, 8'h00, 3'd0, 3'd0},
          EXP_TYPED, '{ACT_DELIVER, 3'd0, 8'h80, 8'h55, 8'hFF, 8'h00, 1'b1}},
        '{1'b0, 8'h00, 4'd0, '{CMD_PACKET, 8'h01, 8'h02, 8'h00, 8'h7F, 3'd0, 3'd3},
          EXP_PREDICTED, NO_WORD},
        // no ports in use: floods give nothing
        '{1'b1, 8'h00, 4'd0, '{CMD_START, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 3'd0},
          EXP_SILENT, NO_WORD},
        '{1'b0, 8'h00, 4'd0, '{CMD_PACKET, 8'h02, 8'h41, 8'h42, 8'h04, 3'd1, 3'd0},
          EXP_SILENT, NO_WORD},
        '{1'b0, 8'h00, 4'd0, '{CMD_PACKET, 8'h02, 8'h42, 8'h00, 8'h03, 3'd0, 3'd0},
          EXP_SILENT, NO_WORD},
        // port count above the maximum
        '{1'b1, 8'h5A, 4'hF, '{CMD_START, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 3'd0},
          EXP_PREDICTED, NO_WORD},
        '{1'b0, 8'h00, 4'd0, '{CMD_PACKET, 8'h02, 8'h41, 8'h07, 8'h01, 3'd0, 3'd0},
          EXP_SILENT, NO_WORD},
        '{1'b0, 8'h00, 4'd0, '{CMD_PACKET, 8'h02, 8'h7E, 8'h07, 8'hFE, 3'd4, 3'd0},
          EXP_PREDICTED, NO_WORD},
        '{1'b1, 8'hA5, 4'd3, '{CMD_PACKET, 8'h02, 8'hC3, 8'h3C, 8'h80, 3'd6, 3'd0},
          EXP_PREDICTED, NO_WORD}
    };

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_cfg_we       = 1'b0;
    logic       i_cfg_idx      = 1'b0;
    logic [7:0] i_cfg_data     = 8'h00;
    logic       i_in_valid     = 1'b0;
    logic       i_cmd          = 1'b0;
    logic [7:0] i_pkt_kind     = 8'h00;
    logic [7:0] i_src_node     = 8'h00;
    logic [7:0] i_dst_node     = 8'h00;
    logic [7:0] i_hops_in      = 8'h00;
    logic [2:0] i_arrival_port = 3'd0;
    logic [2:0] i_carried_port = 3'd0;
    logic       i_out_stall    = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic       o_action;
    logic [2:0] o_send_port;
    logic [7:0] o_out_kind;
    logic [7:0] o_out_src;
    logic [7:0] o_out_dst;
    logic [7:0] o_hops_out;
    logic       o_last;

    // bench copy of configuration and tables
    logic [7:0] my_node  = 8'h00;
    logic [3:0] my_ports = 4'd1;
    bit         seen_tab  [256];
    logic [7:0] best_cost [256];
    logic [2:0] best_port [256];
    bit         rt_valid  [256];
    logic [2:0] rt_port   [256];
    bit         frozen    = 1'b0;

    t_fwd_word  emit_q[$];
    t_fwd_word  pending_words[$];
    logic [7:0] src_pool [POOL_SIZE];
    int         mismatch_cnt  = 0;
    bit         long_hold_req = 1'b0;
    bit         tail_quiet    = 1'b0;

    flood_learn_route_forwarder_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_pkt_kind     (i_pkt_kind),
        .i_src_node     (i_src_node),
        .i_dst_node     (i_dst_node),
        .i_hops_in      (i_hops_in),
        .i_arrival_port (i_arrival_port),
        .i_carried_port (i_carried_port),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_action       (o_action),
        .o_send_port    (o_send_port),
        .o_out_kind     (o_out_kind),
        .o_out_src      (o_out_src),
        .o_out_dst      (o_out_dst),
        .o_hops_out     (o_hops_out),
        .o_last         (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [7:0] hop_up(input logic [7:0] h);
        logic [8:0] sum;
        sum = {1'b0, h} + 9'd1;
        return sum[8] ? 8'hFF : sum[7:0];
    endfunction

    // Append one word to the words of the current item.
    function automatic void queue_emit(input t_fwd_word w);
        emit_q = {emit_q, w};
    endfunction

    // Append one word to the words still owed by the block.
    function automatic void queue_pending(input t_fwd_word w);
        pending_words = {pending_words, w};
    endfunction

    function automatic void flood_words(input logic [7:0] kind, input logic [7:0] src,
                                        input logic [7:0] dst, input logic [7:0] hops);
        int n;
        n = (my_ports > 4'd8) ? 8 : int'(my_ports);
        for (int k = 0; k < n; k++) begin
            queue_emit(t_fwd_word'{ACT_SEND, 3'(k), kind, src, dst, hops, 1'(k == n - 1)});
        end
    endfunction

    // Words one packet or command gives, in order; tables advance as a side effect.
    // Addresses are 8 bits wide, so every one has a table entry.
    function automatic void emitted_words(input t_pkt p);
        logic       disc;
        logic [2:0] port;
        emit_q.delete();
        disc = (p.kind == KIND_DISCOVERY) && (p.hops != 8'd0);
        if (p.cmd == CMD_START) begin
            flood_words(KIND_DISCOVERY, my_node, my_node, HOP_START);
            return;
        end
        if (disc && p.dst == my_node) begin
            return;
        end
        if (p.kind != KIND_DISCOVERY && p.dst == my_node) begin
            queue_emit(t_fwd_word'{ACT_DELIVER, 3'd0, p.kind, p.src, p.dst, p.hops, 1'b1});
            return;
        end
        if (disc) begin
            if (seen_tab[p.src]) begin
                // keep the cheapest arrival, lower port on a tie
                if (p.src != my_node && (p.hops < best_cost[p.src] ||
                    (p.hops == best_cost[p.src] && p.arr < best_port[p.src]))) begin
                    best_cost[p.src] = p.hops;
                    best_port[p.src] = p.arr;
                end
                return;
            end
            seen_tab[p.src]  = 1'b1;
            best_cost[p.src] = p.hops;
            best_port[p.src] = p.arr;
            flood_words(p.kind, p.src, p.dst, hop_up(p.hops));
            return;
        end
        if (!frozen) begin
            for (int i = 0; i < 256; i++) begin
                rt_valid[i] = seen_tab[i];
                rt_port[i]  = seen_tab[i] ? best_port[i] : 3'd0;
            end
            frozen = 1'b1;
        end
        port = rt_valid[p.dst] ? rt_port[p.dst] : p.car;
        queue_emit(t_fwd_word'{ACT_SEND, port, p.kind, p.src, p.dst, hop_up(p.hops), 1'b1});
    endfunction

    function automatic logic [7:0] pooled_addr();
        if ($urandom_range(0, 99) < 85) begin
            return src_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic t_pkt rand_pkt();
        t_pkt p;
        int   pick;
        p = '{CMD_PACKET, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              3'($urandom_range(0, 7)), 3'($urandom_range(0, 7))};
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            p.cmd = CMD_START;
        end else if (pick < 55) begin
            p.kind = KIND_DISCOVERY;
            p.src  = pooled_addr();
            case ($urandom_range(0, 9))
                0:       p.hops = 8'hFF;
                1:       p.hops = 8'($urandom_range(1, 255));
                default: p.hops = 8'($urandom_range(1, 8));
            endcase
            if ($urandom_range(0, 9) == 0) begin
                p.dst = my_node;
            end
        end else if (pick < 70) begin
            p.dst = pooled_addr();
        end else if (pick < 80) begin
            p.kind = KIND_DISCOVERY;
            p.hops = 8'd0;
            p.dst  = pooled_addr();
        end else if (pick < 90) begin
            p.dst = my_node;
            if (p.kind == KIND_DISCOVERY) begin
                p.kind = 8'h00;
            end
        end
        return p;
    endfunction

    task automatic offer_pkt(input t_pkt p);
        i_in_valid     <= 1'b1;
        i_cmd          <= p.cmd;
        i_pkt_kind     <= p.kind;
        i_src_node     <= p.src;
        i_dst_node     <= p.dst;
        i_hops_in      <= p.hops;
        i_arrival_port <= p.arr;
        i_carried_port <= p.car;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic sender_gap();
        if (!tail_quiet && $urandom_range(0, 99) < 25) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        if (idx == CFG_NODE_ID) begin
            my_node = val;
        end else begin
            my_ports = val[3:0];
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drain the block, let any silent work finish, then write both registers.
    task automatic set_config(input logic [7:0] node, input logic [3:0] ports);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_words.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        write_reg(CFG_NODE_ID, node);
        write_reg(CFG_NUM_PORTS, {4'h0, ports});
    endtask

    function automatic void cmp_field(input string name, input logic [7:0] exp_v,
                                      input logic [7:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected 'h%0h, got 'h%0h", name, exp_v, got_v);
            mismatch_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin : out_mon
        t_fwd_word w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_words.size() == 0) begin
                $error("word with none due: port %0d kind 'h%0h src 'h%0h dst 'h%0h",
                       o_send_port, o_out_kind, o_out_src, o_out_dst);
                mismatch_cnt++;
            end else begin
                w = pending_words.pop_front();
                cmp_field("action",    w.action, o_action);
                cmp_field("send_port", w.port,   o_send_port);
                cmp_field("out_kind",  w.kind,   o_out_kind);
                cmp_field("out_src",   w.src,    o_out_src);
                cmp_field("out_dst",   w.dst,    o_out_dst);
                cmp_field("hops_out",  w.hops,   o_hops_out);
                cmp_field("last",      w.last,   o_last);
            end
        end
    end

    initial begin : out_stall_gen
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (!tail_quiet && $urandom_range(0, 99) < 30) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else begin
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    initial begin : stim
        t_row       r;
        t_pkt       p;
        logic [7:0] node;
        logic [3:0] ports;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[k]) begin
            r = DIRECTED[k];
            if (r.do_cfg) begin
                set_config(r.node, r.ports);
            end
            offer_pkt(r.pkt);
            emitted_words(r.pkt);
            case (r.mode)
                EXP_PREDICTED: foreach (emit_q[j]) queue_pending(emit_q[j]);
                EXP_TYPED:     queue_pending(r.word);
                default:       ;
            endcase
            sender_gap();
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0:       begin node = 8'h00; ports = 4'd1; end
                1:       begin node = 8'($urandom_range(0, 255)); ports = 4'd8; end
                2:       begin node = 8'hFF; ports = 4'($urandom_range(1, 8)); end
                3:       begin node = 8'($urandom_range(0, 255));
                               ports = 4'($urandom_range(9, 15)); end
                default: begin node = 8'($urandom_range(0, 255));
                               ports = 4'($urandom_range(1, 8)); end
            endcase
            set_config(node, ports);
            foreach (src_pool[j]) src_pool[j] = 8'($urandom_range(0, 255));
            if (ph == 2) begin
                long_hold_req = 1'b1;
            end
            if (ph == NUM_PHASES - 1) begin
                tail_quiet = 1'b1;
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 4 && k == PHASE_ITEMS / 2) begin
                    // hold the sender until everything owed has come out
                    i_in_valid <= 1'b0;
                    do @(posedge i_clk); while (pending_words.size() != 0);
                end
                p = rand_pkt();
                offer_pkt(p);
                emitted_words(p);
                foreach (emit_q[j]) queue_pending(emit_q[j]);
                // keep offering back to back while the receiver holds off
                if (!(ph == 2 && k < 40)) begin
                    sender_gap();
                end
            end
        end

        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_words.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin : watchdog
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> flood_learn_route_forwarder_top.f
rtl/core/flr_pkg.sv
rtl/core/flr_ctrl.sv
rtl/core/flr_dpath.sv
rtl/core/flood_learn_route_forwarder_top.sv
tb/sv/tb_flood_learn_route_forwarder_top.sv
